// ----- sv/mf3_pkg.sv -----
// ----------------------------------------------------------------------------
// mf3_pkg: shared types and constants of the 3x3 median filter
// Beat layouts, register map and sizing constants used by every module.
// ----------------------------------------------------------------------------
package mf3_pkg;

    localparam int DATA_W           = 8;
    localparam int ROW_W            = 12;
    localparam int COL_OUT_W        = 10;
    localparam int CHAN_OUT_W       = 2;
    localparam int WIN_TAPS         = 9;
    localparam int MAX_HEIGHT       = 4096;
    localparam int DEF_MAX_WIDTH    = 1024;
    localparam int DEF_MAX_CHANNELS = 4;
    localparam int MID_DEPTH        = 4;
    localparam int OUT_DEPTH        = 8;
    localparam int APB_ADDR_W       = 4;

    // Register map, by word index.
    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

    localparam logic [10:0] RST_IMAGE_WIDTH   = 11'd640;
    localparam logic [12:0] RST_IMAGE_HEIGHT  = 13'd480;
    localparam logic [2:0]  RST_CHANNEL_COUNT = 3'd1;

    typedef struct packed {
        logic [10:0] image_width;
        logic [12:0] image_height;
        logic [2:0]  channel_count;
    } cfg_t;

    typedef struct packed {
        logic [DATA_W-1:0] sample;
        logic              frame_start;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0]     median_value;
        logic [ROW_W-1:0]      out_row;
        logic [COL_OUT_W-1:0]  out_col;
        logic [CHAN_OUT_W-1:0] out_chan;
        logic                  frame_last;
    } result_t;

    typedef struct packed {
        logic [ROW_W-1:0]      out_row;
        logic [COL_OUT_W-1:0]  out_col;
        logic [CHAN_OUT_W-1:0] out_chan;
        logic                  frame_last;
    } meta_t;

    // One classified sample handed from the front to the back.
    typedef struct packed {
        logic [DATA_W-1:0] sample;
        logic [DATA_W-1:0] above2;
        logic [DATA_W-1:0] above1;
        logic              emit;
        meta_t             meta;
    } mid_item_t;

endpackage

// ----- sv/mf3_regs.sv -----
// ----------------------------------------------------------------------------
// mf3_regs: configuration registers
// APB-style register file holding image width, height and channel count.
// ----------------------------------------------------------------------------
module mf3_regs
    import mf3_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    logic [1:0] reg_index;
    logic       wr_en;

    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width   <= RST_IMAGE_WIDTH;
            cfg_reg.image_height  <= RST_IMAGE_HEIGHT;
            cfg_reg.channel_count <= RST_CHANNEL_COUNT;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_IMAGE_WIDTH:   cfg_reg.image_width   <= pwdata[10:0];
                REG_IMAGE_HEIGHT:  cfg_reg.image_height  <= pwdata[12:0];
                REG_CHANNEL_COUNT: cfg_reg.channel_count <= pwdata[2:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_IMAGE_WIDTH:   prdata = {21'd0, cfg_reg.image_width};
            REG_IMAGE_HEIGHT:  prdata = {19'd0, cfg_reg.image_height};
            REG_CHANNEL_COUNT: prdata = {29'd0, cfg_reg.channel_count};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

// ----- sv/mf3_fifo.sv -----
// ----------------------------------------------------------------------------
// mf3_fifo: small synchronous queue
// Register-based first-in first-out buffer with an occupancy count.
// ----------------------------------------------------------------------------
module mf3_fifo
    import mf3_pkg::*;
#(
    parameter int  DEPTH  = MID_DEPTH,
    parameter type ITEM_T = mid_item_t
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  ITEM_T                      push_item,
    input  logic                       pop,
    output ITEM_T                      pop_item,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ITEM_T            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign empty    = (count_reg == '0);
    assign count    = count_reg;
    assign pop_item = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- sv/mf3_front.sv -----
// ----------------------------------------------------------------------------
// mf3_front: position tracking and line stores
// Accepts samples, keeps the raster position, reads the two rows above
// from the line stores and classifies each sample for the back end.
// ----------------------------------------------------------------------------
module mf3_front
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  cfg_t                           cfg,
    input  logic                           push,
    input  in_item_t                       item,
    output logic                           full,
    input  logic [$clog2(MID_DEPTH+1)-1:0] mid_count,
    output logic                           mid_push,
    output mid_item_t                      mid_item
);

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int CH_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int ADDR_W   = COL_W + CH_W;
    localparam int LS_DEPTH = MAX_WIDTH << CH_W;
    localparam int MCNT_W   = $clog2(MID_DEPTH + 1);

    // Older row (two above) and newer row (one above) of every column and channel.
    logic [DATA_W-1:0] ls_old [LS_DEPTH];
    logic [DATA_W-1:0] ls_new [LS_DEPTH];

    logic [ROW_W-1:0] row_reg, row_next, row_n;
    logic [COL_W-1:0] col_reg, col_next, col_n, col_m1;
    logic [CH_W-1:0]  chan_reg, chan_next, chan_n;

    logic [12:0]      w_ext, h_lim;
    logic [COL_W:0]   w_lim;
    logic [2:0]       nc_lim;
    logic [2:0]       chan_inc;
    logic [COL_W:0]   col_inc;
    logic [ROW_W:0]   row_inc;
    logic             accept;
    logic [ADDR_W-1:0] addr;

    logic              s1_vld_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [DATA_W-1:0] s1_sample_reg;
    logic              s1_emit_reg;
    meta_t             s1_meta_reg;
    logic [DATA_W-1:0] rd_old_reg, rd_new_reg;

    logic              emit;
    meta_t             meta;

    // Space is reserved for the beat already in flight toward the queue.
    assign full   = ({1'b0, mid_count} + (MCNT_W + 1)'(s1_vld_reg)) >= (MCNT_W + 1)'(MID_DEPTH);
    assign accept = push && !full;

    always_comb
    begin
        w_ext = {2'd0, cfg.image_width};
        if (w_ext < 13'd3)
        begin
            w_ext = 13'd3;
        end
        else if (w_ext > 13'(MAX_WIDTH))
        begin
            w_ext = 13'(MAX_WIDTH);
        end
        w_lim = w_ext[COL_W:0];

        h_lim = cfg.image_height;
        if (h_lim < 13'd3)
        begin
            h_lim = 13'd3;
        end
        else if (h_lim > 13'(MAX_HEIGHT))
        begin
            h_lim = 13'(MAX_HEIGHT);
        end

        nc_lim = cfg.channel_count;
        if (nc_lim < 3'd1)
        begin
            nc_lim = 3'd1;
        end
        else if (nc_lim > 3'(MAX_CHANNELS))
        begin
            nc_lim = 3'(MAX_CHANNELS);
        end
    end

    // Position of this sample: frame start or a stale counter restarts at zero.
    always_comb
    begin
        row_n  = (item.frame_start || ({1'b0, row_reg} >= h_lim)) ? '0 : row_reg;
        col_n  = (item.frame_start || ({1'b0, col_reg} >= w_lim)) ? '0 : col_reg;
        chan_n = (item.frame_start || (3'(chan_reg) >= nc_lim)) ? '0 : chan_reg;

        chan_inc = 3'(chan_n) + 3'd1;
        col_inc  = {1'b0, col_n} + 1'b1;
        row_inc  = {1'b0, row_n} + 1'b1;

        chan_next = chan_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        if (accept)
        begin
            chan_next = chan_n;
            col_next  = col_n;
            row_next  = row_n;
            if (chan_inc >= nc_lim)
            begin
                chan_next = '0;
                if (col_inc >= w_lim)
                begin
                    col_next = '0;
                    row_next = (row_inc >= h_lim) ? '0 : row_inc[ROW_W-1:0];
                end
                else
                begin
                    col_next = col_inc[COL_W-1:0];
                end
            end
            else
            begin
                chan_next = chan_inc[CH_W-1:0];
            end
        end
    end

    always_comb
    begin
        addr   = {col_n, chan_n};
        emit   = (row_n >= ROW_W'(2)) && (col_n >= COL_W'(2));
        col_m1 = col_n - COL_W'(1);
        meta.out_row    = row_n - ROW_W'(1);
        meta.out_col    = COL_OUT_W'(col_m1);
        meta.out_chan   = CHAN_OUT_W'(chan_n);
        meta.frame_last = ({1'b0, row_n} == h_lim - 13'd1)
                       && ({1'b0, col_n} == w_lim - 1'b1)
                       && (3'(chan_n) == nc_lim - 3'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg    <= '0;
            col_reg    <= '0;
            chan_reg   <= '0;
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            row_reg    <= row_next;
            col_reg    <= col_next;
            chan_reg   <= chan_next;
            s1_vld_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg   <= addr;
            s1_sample_reg <= item.sample;
            s1_emit_reg   <= emit;
            s1_meta_reg   <= meta;
        end
    end

    // The newer row takes the sample now; its old value moves to the older row
    // in the next cycle. A beat that follows at once on the same entry, as after
    // two frame starts in a row, takes that moving value straight from the read.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_new_reg   <= ls_new[addr];
            ls_new[addr] <= item.sample;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (s1_vld_reg && (s1_addr_reg == addr))
            begin
                rd_old_reg <= rd_new_reg;
            end
            else
            begin
                rd_old_reg <= ls_old[addr];
            end
        end
        if (s1_vld_reg)
        begin
            ls_old[s1_addr_reg] <= rd_new_reg;
        end
    end

    assign mid_push        = s1_vld_reg;
    assign mid_item.sample = s1_sample_reg;
    assign mid_item.above2 = rd_old_reg;
    assign mid_item.above1 = rd_new_reg;
    assign mid_item.emit   = s1_emit_reg;
    assign mid_item.meta   = s1_meta_reg;

endmodule

// ----- sv/mf3_back.sv -----
// ----------------------------------------------------------------------------
// mf3_back: window columns and median network
// Shifts each beat into its channel's 3x3 window and finds the median in
// a three-stage pipeline: column sort, row selection, final median.
// ----------------------------------------------------------------------------
module mf3_back
    import mf3_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           mid_empty,
    input  mid_item_t                      mid_item,
    output logic                           mid_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
    output logic                           res_push,
    output result_t                        res_item
);

    localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

    function automatic logic [DATA_W-1:0] min2(input logic [DATA_W-1:0] a,
                                               input logic [DATA_W-1:0] b);
        min2 = (a < b) ? a : b;
    endfunction

    function automatic logic [DATA_W-1:0] max2(input logic [DATA_W-1:0] a,
                                               input logic [DATA_W-1:0] b);
        max2 = (a < b) ? b : a;
    endfunction

    function automatic logic [DATA_W-1:0] med3(input logic [DATA_W-1:0] a,
                                               input logic [DATA_W-1:0] b,
                                               input logic [DATA_W-1:0] c);
        med3 = max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    logic [DATA_W-1:0] win_reg [MAX_CHANNELS][WIN_TAPS];
    logic [DATA_W-1:0] win_new [WIN_TAPS];
    logic [CH_W-1:0]   ch;
    logic [OCNT_W:0]   in_flight;

    logic              w_vld_reg, s_vld_reg, m_vld_reg;
    logic [DATA_W-1:0] w_win_reg [WIN_TAPS];
    meta_t             w_meta_reg, s_meta_reg, m_meta_reg;
    logic [DATA_W-1:0] s_lo_reg [3];
    logic [DATA_W-1:0] s_mid_reg [3];
    logic [DATA_W-1:0] s_hi_reg [3];
    logic [DATA_W-1:0] m_a_reg, m_b_reg, m_c_reg;

    assign ch = mid_item.meta.out_chan[CH_W-1:0];

    // A beat is taken only when the result queue has room for everything in flight.
    assign in_flight = {1'b0, out_count} + (OCNT_W + 1)'(w_vld_reg)
                     + (OCNT_W + 1)'(s_vld_reg) + (OCNT_W + 1)'(m_vld_reg);
    assign mid_pop   = !mid_empty && (in_flight < (OCNT_W + 1)'(OUT_DEPTH));

    // Window is column-major, oldest column first; the new column enters last.
    always_comb
    begin
        for (int k = 0; k < WIN_TAPS - 3; k++)
        begin
            win_new[k] = win_reg[ch][k + 3];
        end
        win_new[WIN_TAPS - 3] = mid_item.above2;
        win_new[WIN_TAPS - 2] = mid_item.above1;
        win_new[WIN_TAPS - 1] = mid_item.sample;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_vld_reg <= 1'b0;
            s_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
        end
        else
        begin
            w_vld_reg <= mid_pop && mid_item.emit;
            s_vld_reg <= w_vld_reg;
            m_vld_reg <= s_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_pop)
        begin
            for (int k = 0; k < WIN_TAPS; k++)
            begin
                win_reg[ch][k] <= win_new[k];
                w_win_reg[k]   <= win_new[k];
            end
            w_meta_reg <= mid_item.meta;
        end

        for (int c = 0; c < 3; c++)
        begin
            s_lo_reg[c]  <= min2(min2(w_win_reg[3*c], w_win_reg[3*c+1]), w_win_reg[3*c+2]);
            s_mid_reg[c] <= med3(w_win_reg[3*c], w_win_reg[3*c+1], w_win_reg[3*c+2]);
            s_hi_reg[c]  <= max2(max2(w_win_reg[3*c], w_win_reg[3*c+1]), w_win_reg[3*c+2]);
        end
        s_meta_reg <= w_meta_reg;

        m_a_reg    <= max2(max2(s_lo_reg[0], s_lo_reg[1]), s_lo_reg[2]);
        m_b_reg    <= med3(s_mid_reg[0], s_mid_reg[1], s_mid_reg[2]);
        m_c_reg    <= min2(min2(s_hi_reg[0], s_hi_reg[1]), s_hi_reg[2]);
        m_meta_reg <= s_meta_reg;
    end

    assign res_push              = m_vld_reg;
    assign res_item.median_value = med3(m_a_reg, m_b_reg, m_c_reg);
    assign res_item.out_row      = m_meta_reg.out_row;
    assign res_item.out_col      = m_meta_reg.out_col;
    assign res_item.out_chan     = m_meta_reg.out_chan;
    assign res_item.frame_last   = m_meta_reg.frame_last;

endmodule

// ----- sv/median_filter_3x3_top.sv -----
// A result passes front stage, mid queue, window, sort and select stages and out queue.
// Throughput: one sample per cycle unless full; one beat per stage per cycle unless held.
// Border samples update the stores and windows but give no result beat.
// Reset: position counters clear and registers take their defaults; the line stores
// and window columns are not cleared and hold unknown data until written.
// ----------------------------------------------------------------------------
// median_filter_3x3_top: streaming 3x3 median filter
// Front end with line stores, a short queue, and a back end with windows and
// median network feeding a result queue.
// ----------------------------------------------------------------------------
module median_filter_3x3_top
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  push,
    input  in_item_t              item,
    output logic                  full,
    output logic                  empty,
    input  logic                  pop,
    output result_t               result
);

    cfg_t                           cfg;
    logic                           mid_push, mid_pop, mid_empty;
    mid_item_t                      mid_in, mid_out;
    logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
    logic                           res_push;
    result_t                        res_item;
    logic [$clog2(OUT_DEPTH+1)-1:0] out_count;
    logic                           out_pop;

    assign out_pop = pop && !empty;

    mf3_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mf3_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .push      (push),
        .item      (item),
        .full      (full),
        .mid_count (mid_count),
        .mid_push  (mid_push),
        .mid_item  (mid_in)
    );

    mf3_fifo #(
        .DEPTH  (MID_DEPTH),
        .ITEM_T (mid_item_t)
    ) u_mid_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (mid_push),
        .push_item (mid_in),
        .pop       (mid_pop),
        .pop_item  (mid_out),
        .empty     (mid_empty),
        .count     (mid_count)
    );

    mf3_back #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_item  (mid_out),
        .mid_pop   (mid_pop),
        .out_count (out_count),
        .res_push  (res_push),
        .res_item  (res_item)
    );

    mf3_fifo #(
        .DEPTH  (OUT_DEPTH),
        .ITEM_T (result_t)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_item (res_item),
        .pop       (out_pop),
        .pop_item  (result),
        .empty     (empty),
        .count     (out_count)
    );

endmodule
